/* src/fim_pkg.sv */
// Package of types, codes and constants shared by the frame interval monitor.
package fim_pkg;

	// Widths of the time base, the request counter and the registers.
	localparam int TIME_BITS  = 48;
	localparam int COUNT_BITS = 8;
	localparam int REG_BITS   = 20;
	localparam int REG_INDEX_BITS = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Register indexes on the configuration port.
	localparam logic [REG_INDEX_BITS-1:0] REG_MIN_INTERVAL   = 2'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_MAX_INTERVAL   = 2'd1;
	localparam logic [REG_INDEX_BITS-1:0] REG_BOOST_INTERVAL = 2'd2;
	localparam logic [REG_INDEX_BITS-1:0] REG_IDLE_INTERVAL  = 2'd3;

	// Register values after reset.
	localparam logic [REG_BITS-1:0] MIN_INTERVAL_RESET   = 20'd8333;
	localparam logic [REG_BITS-1:0] MAX_INTERVAL_RESET   = 20'd100000;
	localparam logic [REG_BITS-1:0] BOOST_INTERVAL_RESET = 20'd16666;
	localparam logic [REG_BITS-1:0] IDLE_INTERVAL_RESET  = 20'd33000;

	// Event operation codes.
	localparam logic [2:0] OP_FRAME  = 3'd0;
	localparam logic [2:0] OP_USER   = 3'd1;
	localparam logic [2:0] OP_PANEL  = 3'd2;
	localparam logic [2:0] OP_ENABLE = 3'd3;
	localparam logic [2:0] OP_BLOCK  = 3'd4;
	localparam logic [2:0] OP_TICK   = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_NOTICE = 2'd2;
	localparam logic [1:0] KIND_IDLE   = 2'd3;

	typedef logic [TIME_BITS-1:0] time_us_t;
	typedef logic [REG_BITS-1:0]  interval_t;

	// One result item as it is held in the output queue.
	typedef struct packed {
		logic [1:0] kind;
		interval_t  interval_us;
		logic       blocked;
		logic       refused;
		logic       last;
	} fim_result_t;

	// Time since an earlier stamp; a stamp in the future counts as no time at all.
	function automatic time_us_t elapsed(time_us_t now, time_us_t then);
		return (now >= then) ? time_us_t'(now - then) : '0;
	endfunction

	// Clamp to the window; the lower bound is checked first.
	function automatic interval_t clamp_iv(time_us_t v, interval_t lo, interval_t hi);
		if (v < time_us_t'(lo)) begin
			return lo;
		end
		if (v > time_us_t'(hi)) begin
			return hi;
		end
		return v[REG_BITS-1:0];
	endfunction

	// Build one result item.
	function automatic fim_result_t make_result(logic [1:0] kind, interval_t iv,
			logic blk, logic refused, logic last);
		fim_result_t r;
		r.kind        = kind;
		r.interval_us = iv;
		r.blocked     = blk;
		r.refused     = refused;
		r.last        = last;
		return r;
	endfunction

endpackage

/* src/fim_channels.sv */
// Valid/ready channel interfaces for events in and results out.
interface fim_event_if
	import fim_pkg::*;
	();
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	time_us_t   timestamp_us;
	logic       switch_on;

	modport source (output valid, output operation, output timestamp_us, output switch_on,
		input ready);
	modport sink (input valid, input operation, input timestamp_us, input switch_on,
		output ready);
endinterface

interface fim_result_if
	import fim_pkg::*;
	();
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	interval_t  interval_us;
	logic       blocked;
	logic       refused;
	logic       last;

	modport source (output valid, output kind, output interval_us, output blocked,
		output refused, output last, input ready);
	modport sink (input valid, input kind, input interval_us, input blocked,
		input refused, input last, output ready);
endinterface

/* src/fim_out_queue.sv */
// Two-entry result queue that takes one or two results at once and drives the result channel.
module fim_out_queue
	import fim_pkg::*;
	(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         push_two,
	input  fim_result_t  first,
	input  fim_result_t  second,
	output logic [1:0]   fill,
	fim_result_if.source res
);

	fim_result_t entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign pop  = res.valid && res.ready;
	assign fill = count_q;

	// Head of the queue onto the channel.
	assign res.valid       = (count_q != 2'd0);
	assign res.kind        = entry_q[rd_ptr_q].kind;
	assign res.interval_us = entry_q[rd_ptr_q].interval_us;
	assign res.blocked     = entry_q[rd_ptr_q].blocked;
	assign res.refused     = entry_q[rd_ptr_q].refused;
	assign res.last        = entry_q[rd_ptr_q].last;

	// Storage; a double push lands in both slots in order.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= first;
			if (push_two) begin
				entry_q[~wr_ptr_q] <= second;
			end
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= push_two ? wr_ptr_q : ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + (push ? (push_two ? 2'd2 : 2'd1) : 2'd0)
				- (pop ? 2'd1 : 2'd0);
		end
	end

endmodule

/* src/frame_interval_monitor.sv */
// Top level of the frame interval monitor: event register, event logic and state.
//
//  Channel   Direction  Transfer when         Payload
//  evt       in         evt.valid & ready     operation, timestamp_us, switch_on
//  res       out        res.valid & ready     kind, interval_us, blocked, refused, last
//  cfg_*     in         cfg_we high           cfg_index, cfg_data (no read-back)
//
// An event is registered on transfer and handled from the event register, which
// updates the state and places its one or two results in a two-entry output queue.
// One event per cycle is sustained while results are taken; an unblock yields two
// results and waits until the output queue is empty.
// Reset sets the screen-on flag, clears the other flags, the counter and the times,
// and loads the register reset values.
// The event register holds while the output queue lacks room for its results.
module frame_interval_monitor
	import fim_pkg::*;
	(
	input  logic                      clk,
	input  logic                      arst_n,
	fim_event_if.sink                 evt,
	fim_result_if.source              res,
	input  logic                      cfg_we,
	input  logic [REG_INDEX_BITS-1:0] cfg_index,
	input  interval_t                 cfg_data
);

	// Configuration registers.
	interval_t min_iv_q, max_iv_q, boost_iv_q, idle_iv_q;

	// Monitor state.
	logic                  screen_on_q, enabled_q, block_q, boost_pending_q, long_timeout_q;
	logic [COUNT_BITS-1:0] count_q;
	time_us_t              prev_time_q, last_report_q;

	// Event register.
	logic       valid_s1;
	logic [2:0] op_s1;
	time_us_t   now_s1;
	logic       on_s1;

	// Next state and results of the event held in the register.
	logic                  screen_on_d, enabled_d, block_d, boost_pending_d, long_timeout_d;
	logic [COUNT_BITS-1:0] count_d;
	time_us_t              prev_time_d, last_report_d;
	fim_result_t           first, second;
	logic                  two;
	logic [1:0]            fill;
	logic                  commit;
	time_us_t              since_frame, since_report;
	interval_t             timeout;

	assign since_frame  = elapsed(now_s1, prev_time_q);
	assign since_report = elapsed(now_s1, last_report_q);
	assign timeout      = long_timeout_q ? max_iv_q : idle_iv_q;

	// The event commits once the queue has room for all its results.
	assign commit    = valid_s1 && (two ? (fill == 2'd0) : (fill != 2'd2));
	assign evt.ready = !valid_s1 || commit;

	// Event decode and state update.
	always_comb begin
		screen_on_d     = screen_on_q;
		enabled_d       = enabled_q;
		block_d         = block_q;
		boost_pending_d = boost_pending_q;
		long_timeout_d  = long_timeout_q;
		count_d         = count_q;
		prev_time_d     = prev_time_q;
		last_report_d   = last_report_q;
		first  = make_result(KIND_STATUS, '0, 1'b0, 1'b1, 1'b1);
		second = make_result(KIND_STATUS, '0, 1'b0, 1'b1, 1'b1);
		two    = 1'b0;
		case (op_s1)
			OP_FRAME: begin
				if (enabled_q && screen_on_q) begin
					first = make_result(KIND_REPORT,
						boost_pending_q ? clamp_iv(time_us_t'(min_iv_q), min_iv_q, max_iv_q)
							: clamp_iv(since_frame, min_iv_q, max_iv_q),
						1'b0, 1'b0, 1'b1);
					boost_pending_d = 1'b0;
					prev_time_d     = now_s1;
					last_report_d   = now_s1;
					long_timeout_d  = 1'b0;
				end
			end
			OP_USER: begin
				if (enabled_q) begin
					first = make_result(KIND_REPORT, boost_iv_q, 1'b0, 1'b0, 1'b1);
					boost_pending_d = 1'b1;
					prev_time_d     = now_s1;
					last_report_d   = now_s1;
					long_timeout_d  = 1'b0;
					enabled_d       = screen_on_q;
				end
			end
			OP_PANEL: begin
				if (on_s1 != screen_on_q) begin
					screen_on_d = on_s1;
					if (enabled_q) begin
						first = make_result(KIND_REPORT, boost_iv_q, 1'b0, 1'b0, 1'b1);
						prev_time_d    = now_s1;
						last_report_d  = now_s1;
						long_timeout_d = 1'b0;
						enabled_d      = on_s1;
					end
				end
			end
			OP_ENABLE: begin
				if (on_s1) begin
					count_d = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
				end else begin
					count_d = (count_q != '0) ? count_q - 1'b1 : count_q;
				end
				if (on_s1 != enabled_q) begin
					if (count_d != '0) begin
						if (!enabled_q) begin
							last_report_d  = now_s1;
							long_timeout_d = 1'b0;
						end
						enabled_d = 1'b1;
					end else begin
						enabled_d = 1'b0;
					end
				end
				first = make_result(KIND_STATUS, '0, 1'b0, 1'b0, 1'b1);
			end
			OP_BLOCK: begin
				if (on_s1 == block_q) begin
					first = make_result(KIND_STATUS, '0, 1'b0, 1'b0, 1'b1);
				end else if (on_s1) begin
					block_d = 1'b1;
					first   = make_result(KIND_NOTICE, '0, 1'b1, 1'b0, 1'b1);
				end else begin
					// Unblock: a notice, then the user input action.
					block_d = 1'b0;
					two     = 1'b1;
					first   = make_result(KIND_NOTICE, '0, 1'b0, 1'b0, 1'b0);
					if (enabled_q) begin
						second = make_result(KIND_REPORT, boost_iv_q, 1'b0, 1'b0, 1'b1);
						boost_pending_d = 1'b1;
						prev_time_d     = now_s1;
						last_report_d   = now_s1;
						long_timeout_d  = 1'b0;
						enabled_d       = screen_on_q;
					end
				end
			end
			OP_TICK: begin
				if (enabled_q) begin
					if (since_report < time_us_t'(timeout)) begin
						first = make_result(KIND_STATUS, '0, 1'b0, 1'b0, 1'b1);
					end else begin
						if (screen_on_q) begin
							first = make_result(KIND_IDLE,
								clamp_iv(since_frame, min_iv_q, max_iv_q), 1'b0, 1'b0, 1'b1);
							prev_time_d = now_s1;
						end else begin
							first = make_result(KIND_IDLE, '0, 1'b0, 1'b1, 1'b1);
						end
						last_report_d  = now_s1;
						long_timeout_d = 1'b1;
						enabled_d      = screen_on_q;
					end
				end
			end
			default: begin
				first = make_result(KIND_STATUS, '0, 1'b0, 1'b1, 1'b1);
			end
		endcase
	end

	// Event register payload.
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1  <= evt.operation;
			now_s1 <= evt.timestamp_us;
			on_s1  <= evt.switch_on;
		end
	end

	// Event register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_iv_q   <= MIN_INTERVAL_RESET;
			max_iv_q   <= MAX_INTERVAL_RESET;
			boost_iv_q <= BOOST_INTERVAL_RESET;
			idle_iv_q  <= IDLE_INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_INTERVAL:   min_iv_q   <= cfg_data;
				REG_MAX_INTERVAL:   max_iv_q   <= cfg_data;
				REG_BOOST_INTERVAL: boost_iv_q <= cfg_data;
				REG_IDLE_INTERVAL:  idle_iv_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Monitor state, updated when an event commits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_on_q     <= 1'b1;
			enabled_q       <= 1'b0;
			block_q         <= 1'b0;
			boost_pending_q <= 1'b0;
			long_timeout_q  <= 1'b0;
			count_q         <= '0;
			prev_time_q     <= '0;
			last_report_q   <= '0;
		end else if (commit) begin
			screen_on_q     <= screen_on_d;
			enabled_q       <= enabled_d;
			block_q         <= block_d;
			boost_pending_q <= boost_pending_d;
			long_timeout_q  <= long_timeout_d;
			count_q         <= count_d;
			prev_time_q     <= prev_time_d;
			last_report_q   <= last_report_d;
		end
	end

	fim_out_queue u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (commit),
		.push_two (two),
		.first    (first),
		.second   (second),
		.fill     (fill),
		.res      (res)
	);

endmodule
